### hdl/shrs_pkg.sv
// ----------------------------------------------------------------------------
// shrs_pkg
// Types, codes and sizes shared by the sample history ring slicer.
// ----------------------------------------------------------------------------
package shrs_pkg;

  localparam int DEPTH     = 65536;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int CNT_W     = ADDR_W + 1;
  localparam int PAIR_BITS = 32;
  localparam int LEN_W     = 24;
  localparam int KIND_W    = 2;
  localparam int STAT_W    = 2;
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = $clog2(QDEPTH);

  localparam logic [KIND_W-1:0] KIND_PUSH = 2'd0;
  localparam logic [KIND_W-1:0] KIND_OPEN = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ = 2'd2;
  localparam logic [KIND_W-1:0] KIND_NOP  = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_REFUSED = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd2;

  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(DEPTH);

  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic [31:0]          pair_in;
    logic [LEN_W-1:0]     age_pairs;
    logic [LEN_W-1:0]     duration_pairs;
    logic [LEN_W-1:0]     max_pairs;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0]    status;
    logic [31:0]          pair_out;
    logic [16:0]          slice_count;
    logic                 last;
  } rsp_t;

  typedef struct packed {
    logic [KIND_W-1:0]    op;
    logic [PAIR_BITS-1:0] pair;
    logic [LEN_W-1:0]     age;
    logic [LEN_W-1:0]     dur;
    logic [LEN_W-1:0]     mx;
  } item_t;

endpackage

### hdl/shrs_front.sv
// ----------------------------------------------------------------------------
// shrs_front
// Accepts requests, decodes the kind and queues them for the back end.
// ----------------------------------------------------------------------------
module shrs_front import shrs_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  req_t  in_req,
  output logic  q_valid,
  input  logic  q_pop,
  output item_t q_item
);

  item_t              entry [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QPTR_W:0]    count;
  logic               push;
  logic               pop;
  item_t              decoded;

  always_comb begin
    decoded.op   = in_req.kind;
    decoded.pair = in_req.pair_in[PAIR_BITS-1:0];
    decoded.age  = in_req.age_pairs;
    decoded.dur  = in_req.duration_pairs;
    decoded.mx   = in_req.max_pairs;
  end

  assign in_stall = (count == (QPTR_W+1)'(QDEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != '0);
  assign pop      = q_pop && q_valid;
  assign q_item   = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### hdl/shrs_back.sv
// ----------------------------------------------------------------------------
// shrs_back
// Runs queued requests against the history memory and registers the result.
// ----------------------------------------------------------------------------
module shrs_back import shrs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [16:0] cfg_data,
  input  logic        q_valid,
  output logic        q_pop,
  input  item_t       q_item,
  output logic        out_valid,
  input  logic        out_stall,
  output rsp_t        out_rsp
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_OPEN = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;

  logic [PAIR_BITS-1:0] mem [DEPTH];
  logic [PAIR_BITS-1:0] mem_q;

  logic [1:0]        state;
  logic [CNT_W-1:0]  cap;
  logic [ADDR_W-1:0] wp;
  logic [ADDR_W-1:0] rp;
  logic [CNT_W-1:0]  fill;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  off;
  logic [LEN_W-1:0]  dur;
  logic [LEN_W-1:0]  mx;
  logic              last_flag;

  logic              out_free;
  logic              start;
  logic              mem_we;
  logic [CNT_W-1:0]  cap_next;
  logic [CNT_W-1:0]  wp_inc;
  logic [CNT_W-1:0]  rp_inc;
  logic [LEN_W:0]    off_raw;
  logic [CNT_W-1:0]  off_next;
  logic              refuse;
  logic [CNT_W-1:0]  len_a;
  logic [CNT_W-1:0]  len;
  logic [CNT_W:0]    rp_base;
  logic [CNT_W:0]    rp_start;
  rsp_t              rsp_next;
  logic              rsp_load;

  assign out_free = !out_valid || !out_stall;
  assign start    = (state == S_IDLE) && q_valid && out_free;
  assign q_pop    = start;
  assign mem_we   = start && (q_item.op == KIND_PUSH);

  always_comb begin
    if (cfg_data == '0) begin
      cap_next = CNT_W'(1);
    end else if ({1'b0, cfg_data} > 18'(DEPTH)) begin
      cap_next = CAP_RESET;
    end else begin
      cap_next = cfg_data[CNT_W-1:0];
    end
    wp_inc = {1'b0, wp} + 1'b1;
    rp_inc = {1'b0, rp} + 1'b1;

    refuse = (q_item.dur == '0) || (q_item.mx == '0) || (fill == '0);
    if ({q_item.age, 1'b0} < {1'b0, q_item.dur}) begin
      off_raw = {1'b0, q_item.dur};
    end else begin
      off_raw = {1'b0, q_item.age} + {2'b0, q_item.dur[LEN_W-1:1]};
    end
    if (off_raw > (LEN_W+1)'(fill)) begin
      off_next = fill;
    end else begin
      off_next = off_raw[CNT_W-1:0];
    end

    if (dur > LEN_W'(off)) begin
      len_a = off;
    end else begin
      len_a = dur[CNT_W-1:0];
    end
    if (LEN_W'(len_a) > mx) begin
      len = mx[CNT_W-1:0];
    end else begin
      len = len_a;
    end
    rp_base = {2'b0, wp} + {1'b0, cap};
    if ({1'b0, wp} >= off) begin
      rp_start = {2'b0, wp} - {1'b0, off};
    end else begin
      rp_start = rp_base - {1'b0, off};
    end
  end

  always_comb begin
    rsp_next = '0;
    rsp_load = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (q_item.op)
            KIND_OPEN: begin
              rsp_next.status = ST_REFUSED;
              rsp_load        = refuse;
            end
            KIND_READ: begin
              rsp_next.status = ST_EMPTY;
              rsp_load        = (rem == '0);
            end
            default: begin
              rsp_load = 1'b1;
            end
          endcase
        end
      end
      S_OPEN: begin
        rsp_load = 1'b1;
        if (len == '0) begin
          rsp_next.status = ST_REFUSED;
        end else begin
          rsp_next.slice_count = len;
        end
      end
      S_READ: begin
        rsp_load          = 1'b1;
        rsp_next.pair_out = 32'(mem_q);
        rsp_next.last     = last_flag;
      end
      default: begin
        rsp_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wp] <= q_item.pair;
    end
    mem_q <= mem[rp];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cap       <= CAP_RESET;
      wp        <= '0;
      rp        <= '0;
      fill      <= '0;
      rem       <= '0;
      out_valid <= 1'b0;
    end else if (cfg_we) begin
      cap  <= cap_next;
      wp   <= '0;
      rp   <= '0;
      fill <= '0;
      rem  <= '0;
    end else begin
      out_valid <= rsp_load || (out_valid && out_stall);
      if (rsp_load) begin
        out_rsp <= rsp_next;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            unique case (q_item.op)
              KIND_PUSH: begin
                wp   <= (wp_inc == cap) ? '0 : wp_inc[ADDR_W-1:0];
                fill <= (fill < cap) ? fill + 1'b1 : cap;
                rem  <= '0;
              end
              KIND_OPEN: begin
                rem <= '0;
                if (!refuse) begin
                  off   <= off_next;
                  dur   <= q_item.dur;
                  mx    <= q_item.mx;
                  state <= S_OPEN;
                end
              end
              KIND_READ: begin
                if (rem != '0) begin
                  rp        <= (rp_inc == cap) ? '0 : rp_inc[ADDR_W-1:0];
                  rem       <= rem - 1'b1;
                  last_flag <= (rem == CNT_W'(1));
                  state     <= S_READ;
                end
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_OPEN: begin
          if (len != '0) begin
            rp  <= rp_start[ADDR_W-1:0];
            rem <= len;
          end
          state <= S_IDLE;
        end
        S_READ: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### hdl/sample_history_ring_slicer_core.sv
// ----------------------------------------------------------------------------
// sample_history_ring_slicer_core
// Circular capture buffer of I/Q pairs with slice open and pair readout.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall/in_req carry requests: push a pair, open a slice, or
//   read the next slice pair. out_valid/out_stall/out_rsp carry exactly one
//   result per request, in request order.
//   cfg_we/cfg_data set the capacity in pairs; this clears the history.
//   Write it only while no request is pending.
// Timing:
//   A two-entry queue decouples request intake from the execution side.
//   The executor takes one request at a time: push and unused kinds
//   finish in the idle state, open passes through an open state (offset,
//   then length and start), and read passes through a read state
//   (registered memory read).
// Reset and stall:
//   rst clears history, closes any slice and sets capacity to 65536.
//   Memory contents are not cleared. While out_stall is high the result
//   holds, the executor waits, and in_stall rises once the queue is full.
// ----------------------------------------------------------------------------
module sample_history_ring_slicer_core import shrs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [16:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  req_t        in_req,
  output logic        out_valid,
  input  logic        out_stall,
  output rsp_t        out_rsp
);

  logic  q_valid;
  logic  q_pop;
  item_t q_item;

  shrs_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_req   (in_req),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_item   (q_item)
  );

  shrs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_item    (q_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_rsp   (out_rsp)
  );

endmodule

### hdl/shrs_checker.sv
// ----------------------------------------------------------------------------
// shrs_checker
// Port-level checks on result encoding and output handshake.
// ----------------------------------------------------------------------------
module shrs_checker import shrs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic out_valid,
  input  logic out_stall,
  input  rsp_t out_rsp
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_rsp))
    else $error("stalled result changed");

  a_last_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_rsp.last |-> out_rsp.status == ST_OK && out_rsp.slice_count == '0)
    else $error("last flag on a non-read result");

  a_refused: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_rsp.status == ST_REFUSED |->
      out_rsp.slice_count == '0 && out_rsp.pair_out == '0 && !out_rsp.last)
    else $error("refused open carries data");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_rsp.status == ST_EMPTY |->
      out_rsp.slice_count == '0 && out_rsp.pair_out == '0 && !out_rsp.last)
    else $error("empty read carries data");

endmodule

bind sample_history_ring_slicer_core shrs_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_rsp   (out_rsp)
);
